// ----- sv/cts_pkg.sv -----
// Shared types, constants and the helper function of the chirp tone synthesizer.
package cts_pkg;

	localparam int SINE_TABLE_BITS = 10;
	localparam int FRAME_BITS      = 20;

	localparam int FRM_W      = 20;
	localparam int STEP_W     = 31;
	localparam int SLOPE_W    = 32;
	localparam int LVL_W      = 15;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int PHASE_W    = 32;
	localparam int FRAC_W     = 16;
	localparam int ACC_W      = PHASE_W + FRAC_W;
	localparam int QW         = SINE_TABLE_BITS - 2;
	localparam int F_W        = FRAC_W + 1;
	localparam int COEF_W     = 32;
	localparam int SINE_W     = 15;
	localparam int ENV_W      = 16;
	localparam int SAMPLE_W   = 16;
	localparam int CMP_W      = ((FRAME_BITS > FRM_W) ? FRAME_BITS : FRM_W) + 1;
	localparam int DIVD_W     = ENV_W + FRM_W;
	localparam int DIV_STEPS  = ENV_W;
	localparam int CNT_W      = $clog2(DIV_STEPS);
	localparam int POLY_STEPS = 4;
	localparam int PIDX_W     = $clog2(POLY_STEPS);
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 16;

	localparam logic [ENV_W-1:0]  FULL_SCALE = ENV_W'(32768);
	localparam logic [SINE_W-1:0] SINE_MAX   = SINE_W'(32767);
	localparam logic [F_W-1:0]    F_ONE      = F_W'(65536);

	localparam logic [COEF_W-1:0] SIN_C1 = COEF_W'(1686629713);
	localparam logic [COEF_W-1:0] SIN_C3 = COEF_W'(693598668);
	localparam logic [COEF_W-1:0] SIN_C5 = COEF_W'(85569306);
	localparam logic [COEF_W-1:0] SIN_C7 = COEF_W'(5026995);
	localparam logic [COEF_W-1:0] SIN_C9 = COEF_W'(172273);

	localparam logic [STEP_W-1:0]  RST_START   = STEP_W'(77913238);
	localparam logic [SLOPE_W-1:0] RST_SLOPE   = SLOPE_W'(32'hFC8CA548);
	localparam logic [FRM_W-1:0]   RST_ATTACK  = FRM_W'(4410);
	localparam logic [FRM_W-1:0]   RST_DECAY   = FRM_W'(8820);
	localparam logic [FRM_W-1:0]   RST_RELEASE = FRM_W'(13230);
	localparam logic [FRM_W-1:0]   RST_TOTAL   = FRM_W'(44100);
	localparam logic [LVL_W-1:0]   RST_SUSTAIN = LVL_W'(22938);

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_START_STEP = 3'd0,
		REG_SWEEP      = 3'd1,
		REG_ATTACK     = 3'd2,
		REG_DECAY      = 3'd3,
		REG_RELEASE    = 3'd4,
		REG_TOTAL      = 3'd5,
		REG_SUSTAIN    = 3'd6
	} cfg_reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SETUP,
		S_PREP,
		S_POLY,
		S_SINE,
		S_DIV,
		S_ENV,
		S_WB
	} state_t;

	typedef enum logic [2:0] {
		ENV_ATTACK,
		ENV_DECAY,
		ENV_SUSTAIN,
		ENV_RELEASE,
		ENV_ZERO
	} env_mode_t;

	typedef struct packed {
		logic              accept;
		logic              setup;
		logic              prep;
		logic              poly;
		logic [PIDX_W-1:0] poly_idx;
		logic              sine;
		logic              div;
		logic              env;
		logic              wr_out;
		logic              fin;
	} cmd_t;

	typedef struct packed {
		logic done;
	} stat_t;

	// Horner coefficients after the innermost one, outermost last.
	function automatic logic [COEF_W-1:0] poly_coef(input logic [PIDX_W-1:0] idx);
		logic [COEF_W-1:0] c;
		case (idx)
			2'd0:    c = SIN_C7;
			2'd1:    c = SIN_C5;
			2'd2:    c = SIN_C3;
			default: c = SIN_C1;
		endcase
		return c;
	endfunction

endpackage

// ----- sv/cts_ctrl.sv -----
// Sequencer that steps the datapath through one sample and owns the output valid flag.
module cts_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  logic           m_tready,
	input  cts_pkg::stat_t stat,
	output cts_pkg::cmd_t  cmd
);
	import cts_pkg::*;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             fin_q;
	logic             ov_q;
	logic             out_free;

	assign out_free = !ov_q || m_tready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (s_tvalid) state_d = S_SETUP;
			S_SETUP: state_d = stat.done ? S_WB : S_PREP;
			S_PREP:  state_d = S_POLY;
			S_POLY:  if (cnt_q == CNT_W'(POLY_STEPS - 1)) state_d = S_SINE;
			S_SINE:  state_d = S_DIV;
			S_DIV:   if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = S_ENV;
			S_ENV:   state_d = S_WB;
			S_WB:    if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		s_tready     = (state_q == S_IDLE);
		cmd.accept   = (state_q == S_IDLE) && s_tvalid;
		cmd.setup    = (state_q == S_SETUP);
		cmd.prep     = (state_q == S_PREP);
		cmd.poly     = (state_q == S_POLY);
		cmd.poly_idx = cnt_q[PIDX_W-1:0];
		cmd.sine     = (state_q == S_SINE);
		cmd.div      = (state_q == S_DIV);
		cmd.env      = (state_q == S_ENV);
		cmd.wr_out   = (state_q == S_WB) && out_free;
		cmd.fin      = fin_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			fin_q   <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == S_POLY && cnt_q != CNT_W'(POLY_STEPS - 1)) ||
			    (state_q == S_DIV && cnt_q != CNT_W'(DIV_STEPS - 1))) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else begin
				cnt_q <= '0;
			end
			if (state_q == S_SETUP) begin
				fin_q <= stat.done;
			end
			if (cmd.wr_out) begin
				ov_q <= 1'b1;
			end else if (m_tready) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = ov_q;

	a_accept_setup: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> state_q == S_SETUP)
		else $error("accepted word did not start a sample");

	a_valid_from_write: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ov_q) |-> $past(cmd.wr_out))
		else $error("output valid rose without a result write");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !m_tready && state_q == S_WB) |=> state_q == S_WB && ov_q)
		else $error("pending result left behind while stalled");

endmodule

// ----- sv/cts_dp.sv -----
// Datapath: configuration registers, tone state, sine polynomial, envelope divider and output word.
module cts_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cts_pkg::cmd_t                     cmd,
	output cts_pkg::stat_t                    stat,
	input  logic                              restart,
	input  logic                              cfg_we,
	input  logic [cts_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [cts_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	output logic signed [cts_pkg::SAMPLE_W-1:0] sample,
	output logic                              last,
	output logic                              finished
);
	import cts_pkg::*;

	logic [STEP_W-1:0]  start_q;
	logic [SLOPE_W-1:0] slope_q;
	logic [FRM_W-1:0]   att_q, dec_q, rel_q, tot_q;
	logic [LVL_W-1:0]   sus_q;

	logic [PHASE_W-1:0]    phase_q;
	logic [ACC_W-1:0]      step_q;
	logic [FRAME_BITS-1:0] frame_q;
	logic                  done_q;

	logic [F_W-1:0]    f_q;
	logic              neg_q;
	env_mode_t         mode_q;
	logic [ENV_W-1:0]  num_q;
	logic [FRM_W-1:0]  m_q;
	logic [FRM_W-1:0]  divisor_q;
	logic [F_W-1:0]    x2_q;
	logic [COEF_W-1:0] p_q;
	logic [SINE_W-1:0] sine_q;
	logic [FRM_W-1:0]  rem_q;
	logic [ENV_W-1:0]  qsh_q;
	logic [ENV_W-1:0]  env_q;

	logic signed [SAMPLE_W-1:0] sample_q;
	logic                       last_q;
	logic                       fin_out_q;

	// Sine setup.
	logic [SINE_TABLE_BITS-1:0] idx;
	logic [1:0]                 quad;
	logic [F_W-1:0]             f_base, f_sel;

	assign idx    = phase_q[PHASE_W-1 -: SINE_TABLE_BITS];
	assign quad   = idx[SINE_TABLE_BITS-1 -: 2];
	assign f_base = F_W'(idx[QW-1:0]) << (FRAC_W - QW);
	assign f_sel  = quad[0] ? (F_ONE - f_base) : f_base;

	// Envelope segment selection.
	logic [CMP_W-1:0] n_e, a_e, d_e, r_e, t_e, ad_e, nr_e, na_e, tn_e;
	env_mode_t        mode_d;
	logic [ENV_W-1:0] num_d;
	logic [FRM_W-1:0] m_d, div_d;

	assign n_e  = CMP_W'(frame_q);
	assign a_e  = CMP_W'(att_q);
	assign d_e  = CMP_W'(dec_q);
	assign r_e  = CMP_W'(rel_q);
	assign t_e  = CMP_W'(tot_q);
	assign ad_e = a_e + d_e;
	assign nr_e = n_e + r_e;
	assign na_e = n_e - a_e;
	assign tn_e = t_e - n_e;

	always_comb begin
		mode_d = ENV_ZERO;
		num_d  = FULL_SCALE;
		m_d    = '0;
		div_d  = rel_q;
		if (n_e < a_e) begin
			mode_d = ENV_ATTACK;
			num_d  = FULL_SCALE;
			m_d    = n_e[FRM_W-1:0];
			div_d  = att_q;
		end else if (n_e < ad_e) begin
			mode_d = ENV_DECAY;
			num_d  = FULL_SCALE - ENV_W'(sus_q);
			m_d    = na_e[FRM_W-1:0];
			div_d  = dec_q;
		end else if (nr_e < t_e) begin
			mode_d = ENV_SUSTAIN;
		end else if (rel_q == '0 || t_e <= n_e) begin
			mode_d = ENV_ZERO;
		end else begin
			mode_d = ENV_RELEASE;
			num_d  = ENV_W'(sus_q);
			m_d    = tn_e[FRM_W-1:0];
			div_d  = rel_q;
		end
	end

	// Products and divider step.
	logic [2*F_W-1:0]        x2_prod;
	logic [DIVD_W-1:0]       divd;
	logic [F_W+COEF_W-1:0]   poly_prod;
	logic [F_W+COEF_W-1:0]   sine_prod;
	logic [F_W-1:0]          s_raw;
	logic [FRM_W:0]          trial;
	logic                    ge;
	logic [FRM_W:0]          trial_sub;
	logic [SINE_W+ENV_W-1:0] mag_prod;
	logic [SINE_W-1:0]       mag;
	logic [SAMPLE_W-1:0]     mag_ext;

	assign x2_prod   = f_q * f_q;
	assign divd      = num_q * m_q;
	assign poly_prod = x2_q * p_q;
	assign sine_prod = f_q * p_q;
	assign s_raw     = sine_prod[F_W+30:31];
	assign trial     = {rem_q, qsh_q[ENV_W-1]};
	assign ge        = trial >= {1'b0, divisor_q};
	assign trial_sub = trial - {1'b0, divisor_q};
	assign mag_prod  = sine_q * env_q;
	assign mag       = mag_prod[SINE_W+ENV_W-1 -: SINE_W];
	assign mag_ext   = SAMPLE_W'(mag);

	// Tone end.
	logic [FRAME_BITS:0] nxt;
	logic                last_d;

	assign nxt    = {1'b0, frame_q} + (FRAME_BITS+1)'(1);
	assign last_d = (CMP_W'(nxt) >= t_e) || nxt[FRAME_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= RST_START;
			slope_q <= RST_SLOPE;
			att_q   <= RST_ATTACK;
			dec_q   <= RST_DECAY;
			rel_q   <= RST_RELEASE;
			tot_q   <= RST_TOTAL;
			sus_q   <= RST_SUSTAIN;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				REG_START_STEP: start_q <= cfg_wdata[STEP_W-1:0];
				REG_SWEEP:      slope_q <= cfg_wdata[SLOPE_W-1:0];
				REG_ATTACK:     att_q   <= cfg_wdata[FRM_W-1:0];
				REG_DECAY:      dec_q   <= cfg_wdata[FRM_W-1:0];
				REG_RELEASE:    rel_q   <= cfg_wdata[FRM_W-1:0];
				REG_TOTAL:      tot_q   <= cfg_wdata[FRM_W-1:0];
				REG_SUSTAIN:    sus_q   <= cfg_wdata[LVL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= '0;
			step_q    <= {1'b0, RST_START, {FRAC_W{1'b0}}};
			frame_q   <= '0;
			done_q    <= 1'b0;
			sample_q  <= '0;
			last_q    <= 1'b0;
			fin_out_q <= 1'b0;
		end else if (cmd.accept && restart) begin
			phase_q <= '0;
			step_q  <= {1'b0, start_q, {FRAC_W{1'b0}}};
			frame_q <= '0;
			done_q  <= 1'b0;
		end else if (cmd.wr_out) begin
			if (cmd.fin) begin
				sample_q  <= '0;
				last_q    <= 1'b0;
				fin_out_q <= 1'b1;
			end else begin
				sample_q  <= neg_q ? -mag_ext : mag_ext;
				last_q    <= last_d;
				fin_out_q <= 1'b0;
				phase_q   <= phase_q + step_q[ACC_W-1 -: PHASE_W];
				step_q    <= step_q + {{(ACC_W-SLOPE_W){slope_q[SLOPE_W-1]}}, slope_q};
				frame_q   <= nxt[FRAME_BITS-1:0];
				if (last_d) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			f_q       <= f_sel;
			neg_q     <= quad[1];
			mode_q    <= mode_d;
			num_q     <= num_d;
			m_q       <= m_d;
			divisor_q <= div_d;
		end
		if (cmd.prep) begin
			x2_q  <= x2_prod[2*F_W-2:FRAC_W];
			p_q   <= SIN_C9;
			rem_q <= divd[DIVD_W-1:ENV_W];
			qsh_q <= divd[ENV_W-1:0];
		end
		if (cmd.poly) begin
			p_q <= poly_coef(cmd.poly_idx) - poly_prod[FRAC_W+COEF_W-1:FRAC_W];
		end
		if (cmd.sine) begin
			sine_q <= (s_raw > F_W'(SINE_MAX)) ? SINE_MAX : s_raw[SINE_W-1:0];
		end
		if (cmd.div) begin
			rem_q <= ge ? trial_sub[FRM_W-1:0] : trial[FRM_W-1:0];
			qsh_q <= {qsh_q[ENV_W-2:0], ge};
		end
		if (cmd.env) begin
			case (mode_q)
				ENV_ATTACK:  env_q <= qsh_q;
				ENV_DECAY:   env_q <= FULL_SCALE - qsh_q;
				ENV_SUSTAIN: env_q <= ENV_W'(sus_q);
				ENV_RELEASE: env_q <= qsh_q;
				default:     env_q <= '0;
			endcase
		end
	end

	assign stat.done = done_q;
	assign sample    = sample_q;
	assign last      = last_q;
	assign finished  = fin_out_q;

	a_fin_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		fin_out_q |-> (sample_q == '0 && !last_q))
		else $error("finished word carries a sample or last");

	a_fin_holds_state: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_out && cmd.fin) |=> ($stable(frame_q) && $stable(phase_q) && done_q))
		else $error("finished word changed the tone state");

	a_last_sets_done: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_out && !cmd.fin && last_d) |=> done_q)
		else $error("last frame did not end the tone");

endmodule

// ----- sv/chirp_tone_adsr_synth.sv -----
// Top level of the chirp tone synthesizer with attack, decay, sustain and release envelope.
//
//   Channel  Direction  Contents
//   s_axis   in         tdata[0] restart, other bits zero
//   m_axis   out        tdata sample, tlast last frame, tuser[0] finished
//   cfg      in         cfg_we, cfg_addr register index, cfg_wdata value
//
// A playing sample reaches the output register after setup, preparation, the four Horner
// steps of the sine polynomial, the sine step, the sixteen steps of the envelope divider,
// the envelope step and write-back. The next word can be accepted in the cycle after
// the write. A word after the tone has ended goes from setup straight to write-back.
// Reset clears the tone state and loads the register defaults; no clearing pass is needed.
// A stalled output holds one result; the following sample is still computed and then waits
// in write-back, with the input not ready, until the output register is free.
module chirp_tone_adsr_synth (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [cts_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // restart
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [cts_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // sample
	output logic                                m_axis_tlast,
	output logic [0:0]                          m_axis_tuser,  // finished
	input  logic                                cfg_we,
	input  logic [cts_pkg::CFG_ADDR_W-1:0]      cfg_addr,
	input  logic [cts_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
	import cts_pkg::*;

	cmd_t                       cmd;
	stat_t                      stat;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       fin;

	cts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_axis_tvalid),
		.s_tready (s_axis_tready),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	cts_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.restart   (s_axis_tdata[0]),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.sample    (sample),
		.last      (m_axis_tlast),
		.finished  (fin)
	);

	assign m_axis_tdata = OUT_TDATA_W'(sample);
	assign m_axis_tuser = fin;

endmodule
